### hdl/sitda_pkg.sv
// shared types, constants and microcode table for the decimal text converter
// no dependencies; imported by signed_int_to_decimal_ascii
package sitda_pkg;

   localparam int ValueWidth = 32;
   localparam int CharWidth  = 8;
   localparam int PowWidth   = 34;   // holds 9 * 10^9 and 10^10
   localparam int PowIdxWidth = 4;   // power index 0..10
   localparam int TopPow     = 9;    // highest power of ten for a 32-bit magnitude

   localparam logic [CharWidth-1:0] AsciiZero  = 8'd48;
   localparam logic [CharWidth-1:0] AsciiMinus = 8'd45;

   typedef logic [1:0] step_type;
   localparam step_type StepIdle  = 2'd0;
   localparam step_type StepSign  = 2'd1;
   localparam step_type StepDigit = 2'd2;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_START,
      COND_POW_ZERO
   } cond_type;

   typedef struct packed {
      logic     load;
      logic     emit_sign;
      logic     emit_digit;
      cond_type cond;
      step_type tgt_true;
      step_type tgt_false;
   } uword_type;

   // microcode: idle/load, sign, digit loop over powers of ten
   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      w = '{load: 1'b0, emit_sign: 1'b0, emit_digit: 1'b0, cond: COND_ALWAYS,
            tgt_true: StepIdle, tgt_false: StepIdle};
      unique case (step)
         StepIdle: begin
            w.load      = 1'b1;
            w.cond      = COND_START;
            w.tgt_true  = StepSign;
            w.tgt_false = StepIdle;
         end
         StepSign: begin
            w.emit_sign = 1'b1;
            w.tgt_true  = StepDigit;
         end
         StepDigit: begin
            w.emit_digit = 1'b1;
            w.cond       = COND_POW_ZERO;
            w.tgt_true   = StepIdle;
            w.tgt_false  = StepDigit;
         end
         default: begin
            w.tgt_true = StepIdle;
         end
      endcase
      return w;
   endfunction

   function automatic logic [PowWidth-1:0] pow10(input logic [PowIdxWidth-1:0] k);
      logic [PowWidth-1:0] p;
      unique case (k)
         4'd0:    p = 34'd1;
         4'd1:    p = 34'd10;
         4'd2:    p = 34'd100;
         4'd3:    p = 34'd1000;
         4'd4:    p = 34'd10000;
         4'd5:    p = 34'd100000;
         4'd6:    p = 34'd1000000;
         4'd7:    p = 34'd10000000;
         4'd8:    p = 34'd100000000;
         4'd9:    p = 34'd1000000000;
         4'd10:   p = 34'd10000000000;
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

### hdl/signed_int_to_decimal_ascii.sv
// signed 32-bit integer to decimal ascii text, put out one character at a time
// microcoded sequencer; depends on sitda_pkg
//
// order: a minus sign, for a negative value, comes from the sign step that follows accept;
// digits come from the digit steps, the last character always from the last one, as all ten run
// each item runs accept, the sign step and ten digit steps; a new item is taken only in idle
// busy stays high from accept until the last character is registered; the receiver cannot stall
// reset is synchronous, active high: step counter returns to idle, the strobe and the started flag clear
module signed_int_to_decimal_ascii
   import sitda_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ValueWidth-1:0] req_value,
   output logic                  rsp_strobe,
   output logic [CharWidth-1:0]  rsp_character,
   output logic                  rsp_last
);

   // sequencer state
   step_type                pc_ff, pc_in;
   // datapath registers
   logic [ValueWidth-1:0]   mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [PowIdxWidth-1:0]  pow_ff, pow_in;
   logic                    started_ff, started_in;
   // registered result
   logic                    strobe_ff, strobe_in;
   logic [CharWidth-1:0]    char_ff, char_in;
   logic                    last_ff, last_in;

   uword_type               uw;
   logic                    take;
   logic [PowWidth-1:0]     pow_k;
   logic [PowWidth-1:0]     thr [0:9];
   logic [8:0]              ge;
   logic [3:0]              digit;
   logic [PowWidth-1:0]     sub;
   logic                    emit;

   assign uw   = ucode_rom(pc_ff);
   assign busy = (pc_ff != StepIdle);

   // jump condition of the current control word
   always_comb begin
      case (uw.cond)
         COND_ALWAYS:   take = 1'b1;
         COND_START:    take = start;
         COND_POW_ZERO: take = (pow_ff == '0);
         default:       take = 1'b0;
      endcase
      pc_in = take ? uw.tgt_true : uw.tgt_false;
   end

   // digit at the current power: count the multiples of 10^k that fit,
   // all nine compares against constant multiples in parallel
   always_comb begin
      pow_k  = pow10(pow_ff);
      thr[0] = '0;
      for (int d = 1; d <= 9; d++) begin
         thr[d]  = pow_k * PowWidth'(d);
         ge[d-1] = ({2'b00, mag_ff} >= thr[d]);
      end
      digit = '0;
      for (int i = 0; i < 9; i++) begin
         digit = digit + 4'(ge[i]);
      end
      sub = thr[digit];
   end

   // datapath next values, driven by the control word
   always_comb begin
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      pow_in     = pow_ff;
      started_in = started_ff;
      strobe_in  = 1'b0;
      char_in    = char_ff;
      last_in    = last_ff;
      emit       = 1'b0;

      if (uw.load && start) begin
         neg_in     = req_value[ValueWidth-1];
         // magnitude of the most negative value still fits as unsigned 32 bits
         mag_in     = req_value[ValueWidth-1] ? (~req_value + 1'b1) : req_value;
         pow_in     = PowIdxWidth'(TopPow);
         started_in = 1'b0;
      end

      if (uw.emit_sign && neg_ff) begin
         strobe_in = 1'b1;
         char_in   = AsciiMinus;
         last_in   = 1'b0;
      end

      if (uw.emit_digit) begin
         // leading zeros dropped, but the units digit always goes out
         emit       = (digit != '0) || started_ff || (pow_ff == '0);
         mag_in     = mag_ff - sub[ValueWidth-1:0];
         started_in = started_ff || emit;
         pow_in     = (pow_ff == '0) ? pow_ff : pow_ff - 1'b1;
         if (emit) begin
            strobe_in = 1'b1;
            char_in   = AsciiZero + {4'b0000, digit};
            last_in   = (pow_ff == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= StepIdle;
         strobe_ff  <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         pc_ff      <= pc_in;
         strobe_ff  <= strobe_in;
         started_ff <= started_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      pow_ff  <= pow_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   // an accepted item always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start the sequence");

   // the final character of an item coincides with the return to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> (pc_ff == StepIdle))
      else $error("last character while sequence still running");

   // remaining magnitude is always below the next power of ten
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == StepDigit) |-> ({2'b00, mag_ff} < pow10(pow_ff + 1'b1)))
      else $error("remainder out of range for current digit");

   // a character only comes out after a sign step or a digit step
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(pc_ff) == StepSign || $past(pc_ff) == StepDigit))
      else $error("character strobe without a sign or digit step");

endmodule

### sim/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for signed_int_to_decimal_ascii: directed and random values
// depends on sitda_pkg and the signed_int_to_decimal_ascii rtl
module signed_int_to_decimal_ascii_tb
   import sitda_pkg::*;
();

   // one expected character of a value's decimal text
   typedef struct packed {
      logic [CharWidth-1:0] character;
      logic                 last;
   } text_char_type;

   // holds the text still owed by the block and scores what comes back
   class decimal_text_scoreboard;
      text_char_type owed_chars[$];
      int unsigned   mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      // an accepted item: spell its value and queue every character
      function void note_value(logic [ValueWidth-1:0] value);
         logic [ValueWidth:0] magnitude;
         logic [3:0]          digits [10];
         text_char_type       item;
         int                  ndig;
         int                  i;
         // 33-bit magnitude so the most negative value needs no special path
         if (value[ValueWidth-1]) begin
            magnitude = {1'b1, {ValueWidth{1'b0}}} - {1'b0, value};
         end else begin
            magnitude = {1'b0, value};
         end
         ndig = 0;
         do begin
            digits[ndig] = 4'(magnitude % 10);
            magnitude    = magnitude / 10;
            ndig++;
         end while (magnitude != 0 && ndig < 10);
         if (value[ValueWidth-1]) begin
            item.character = AsciiMinus;
            item.last      = 1'b0;
            owed_chars.push_back(item);
         end
         for (i = ndig - 1; i >= 0; i--) begin
            item.character = AsciiZero + CharWidth'(digits[i]);
            item.last      = (i == 0);
            owed_chars.push_back(item);
         end
      endfunction

      // a character that left the block: compare with the oldest owed one
      function void check_char(logic [CharWidth-1:0] character, logic last);
         text_char_type want;
         if (owed_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: char 0x%02h last %0b with no item pending", character, last);
         end else begin
            want = owed_chars.pop_front();
            if (want.character !== character || want.last !== last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected char 0x%02h last %0b, got char 0x%02h last %0b",
                           want.character, want.last, character, last);
            end
         end
      endfunction

      function int pending();
         return owed_chars.size();
      endfunction
   endclass

   localparam int QuietLimit = 2000;   // cycles with no handshake before we give up

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [ValueWidth-1:0] req_value;
   logic                  rsp_strobe;
   logic [CharWidth-1:0]  rsp_character;
   logic                  rsp_last;

   decimal_text_scoreboard sb;
   int unsigned            quiet_cycles;

   signed_int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   // 12 ns period
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // monitor: everything is sampled at the edge, before this edge's updates land
   // an item is taken when start is high and busy is low
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_value(req_value);
         end
         if (rsp_strobe) begin
            sb.check_char(rsp_character, rsp_last);
         end
      end
   end

   // watchdog: counts edges with neither an accepted item nor a character
   always @(posedge clock) begin
      if ((!reset && start && !busy) || (!reset && rsp_strobe)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // present one value and hold it until the block takes it
   // start stays high on return, so a following call keeps it up without a gap
   task automatic send_value(input logic [ValueWidth-1:0] value);
      req_value <= value;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // sender goes quiet for a number of cycles
   task automatic hold_off(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // sender goes quiet until every owed character has come back
   task automatic drain_text();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // mostly values of a chosen digit count, so every text length shows up often
   function automatic logic [ValueWidth-1:0] random_value();
      logic [ValueWidth-1:0] mag;
      logic [ValueWidth-1:0] lo;
      logic [ValueWidth-1:0] hi;
      int unsigned           decade;
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: mag = $urandom_range(0, 99);
         default: begin
            decade = $urandom_range(0, 9);
            lo = 1;
            repeat (decade) lo = lo * 10;
            // ten-digit magnitudes stop at the largest positive value
            hi = (decade == 9) ? 32'h7fff_ffff : lo * 10 - 1;
            mag = $urandom_range(hi, lo);
         end
      endcase
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // one random phase; idle_pct is the sender's chance to pause after an item
   task automatic run_phase(input int items, input int unsigned idle_pct, input bit with_drain);
      int k;
      for (k = 0; k < items; k++) begin
         send_value(random_value());
         if (with_drain && k == items / 2) begin
            drain_text();
         end else if ($urandom_range(0, 99) < idle_pct) begin
            hold_off($urandom_range(1, 12));
         end
      end
   endtask

   initial begin
      logic [ValueWidth-1:0] directed [0:21];
      int                    k;
      sb        = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero, single digits, decade edges, both extremes, alternating bit patterns
      directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd100,
                   32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
                   32'd1000000000, 32'd999999999, -32'sd999999999, -32'sd1000000000,
                   32'd123456789, -32'sd123456789, 32'd2000000000, 32'd5,
                   32'h5555_5555, 32'haaaa_aaaa, 32'h0000_ffff, 32'hffff_0000};
      // directed values go back to back: start never drops between them
      for (k = 0; k < $size(directed); k++) begin
         send_value(directed[k]);
      end
      hold_off(3);

      run_phase(22, 0, 1'b0);    // sender never idles
      run_phase(24, 53, 1'b1);   // sender idles often, with one full drain midway
      run_phase(22, 0, 1'b0);    // receiver stalls do not exist for this block
      run_phase(22, 8, 1'b0);    // occasional sender gaps
      start <= 1'b0;

      // wait out the owed text, then a margin for any stray strobe
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
